>>> rtl/rwct_pkg.sv
// ----------------------------------------------------------------------------
// rwct_pkg
// Shared types and constants of the relay window cycle timer.
// ----------------------------------------------------------------------------
package rwct_pkg;

  localparam int unsigned DaySeconds = 86400;
  localparam int unsigned WrapGuard  = 7000;
  localparam int unsigned SecPerMin  = 60;
  localparam int unsigned SecPerHour = 3600;

  localparam int unsigned SecW = 17;  // seconds of day
  localparam int unsigned MinW = 11;  // minutes of day

  localparam logic [SecW-1:0] DaySecondsC = SecW'(DaySeconds);
  localparam logic [SecW-1:0] WrapGuardC  = SecW'(WrapGuard);

  // mode bit positions
  localparam int unsigned ModeAuto     = 0;
  localparam int unsigned ModeForceOn  = 1;
  localparam int unsigned ModeForceOff = 2;
  localparam int unsigned ModeWindow   = 3;
  localparam int unsigned ModeRepeat   = 4;

  typedef enum logic [2:0] {
    CfgMode        = 3'd0,
    CfgWindowStart = 3'd1,
    CfgWindowEnd   = 3'd2,
    CfgOffMinutes  = 3'd3,
    CfgOnSeconds   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]  mode_bits;
    logic [10:0] window_start_minute;
    logic [10:0] window_end_minute;
    logic [9:0]  off_minutes;
    logic [9:0]  on_seconds;
  } cfg_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       time_edited;
  } in_t;

  typedef struct packed {
    logic relay_on;
    logic shown_on;
  } out_t;

  // one tick after time-of-day conversion
  typedef struct packed {
    logic [MinW-1:0] now_min;
    logic [SecW-1:0] at_sec;
    logic            edited;
  } tick_t;

endpackage

>>> rtl/rwct_cfg.sv
// ----------------------------------------------------------------------------
// rwct_cfg
// Configuration register file, written through its own valid/ready port.
// ----------------------------------------------------------------------------
module rwct_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [10:0]        cfg_data_i,
  output rwct_pkg::cfg_t     cfg_o
);

  rwct_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_bits           <= 5'd4;
      cfg_q.window_start_minute <= 11'd0;
      cfg_q.window_end_minute   <= 11'd1439;
      cfg_q.off_minutes         <= 10'd1;
      cfg_q.on_seconds          <= 10'd10;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwct_pkg::CfgMode:        cfg_q.mode_bits           <= cfg_data_i[4:0];
        rwct_pkg::CfgWindowStart: cfg_q.window_start_minute <= cfg_data_i;
        rwct_pkg::CfgWindowEnd:   cfg_q.window_end_minute   <= cfg_data_i;
        rwct_pkg::CfgOffMinutes:  cfg_q.off_minutes         <= cfg_data_i[9:0];
        rwct_pkg::CfgOnSeconds:   cfg_q.on_seconds          <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rwct_in_stage.sv
// ----------------------------------------------------------------------------
// rwct_in_stage
// Input register: converts the time of day into minutes and seconds of day.
// ----------------------------------------------------------------------------
module rwct_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rwct_pkg::in_t   in_data_i,
  output logic            tick_valid_o,
  input  logic            tick_take_i,
  output rwct_pkg::tick_t tick_o
);

  localparam int unsigned SecW = rwct_pkg::SecW;
  localparam int unsigned MinW = rwct_pkg::MinW;

  logic            valid_q;
  rwct_pkg::tick_t tick_q;
  rwct_pkg::tick_t tick_d;
  logic [SecW-1:0] sum_sec;
  logic            accept;

  assign in_ready_o   = !valid_q || tick_take_i;
  assign accept       = in_valid_i && in_ready_o;
  assign tick_valid_o = valid_q;
  assign tick_o       = tick_q;

  always_comb begin
    sum_sec = SecW'(in_data_i.hour) * SecW'(rwct_pkg::SecPerHour)
            + SecW'(in_data_i.minute) * SecW'(rwct_pkg::SecPerMin)
            + SecW'(in_data_i.second);
    tick_d.now_min = MinW'(in_data_i.hour) * MinW'(rwct_pkg::SecPerMin)
                   + MinW'(in_data_i.minute);
    // sum stays below two days, one subtract wraps it
    tick_d.at_sec  = (sum_sec >= rwct_pkg::DaySecondsC) ?
                     sum_sec - rwct_pkg::DaySecondsC : sum_sec;
    tick_d.edited  = in_data_i.time_edited;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (tick_take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q <= tick_d;
    end
  end

endmodule

>>> rtl/rwct_core.sv
// ----------------------------------------------------------------------------
// rwct_core
// Mode, window and repeat decision with the channel state and result register.
// ----------------------------------------------------------------------------
module rwct_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rwct_pkg::cfg_t  cfg_i,
  input  logic            tick_valid_i,
  output logic            tick_take_o,
  input  rwct_pkg::tick_t tick_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rwct_pkg::out_t  out_data_o
);

  localparam int unsigned SecW = rwct_pkg::SecW;

  logic            phase_q, phase_d;
  logic            pend_q, pend_d;
  logic [SecW-1:0] tsec_q, tsec_d;
  logic            stat_q, stat_d;
  logic            out_valid_q;
  rwct_pkg::out_t  out_q, out_d;

  logic            force_on, force_off, has_window, has_repeat;
  logic            outside, due, phase_eff;
  logic [SecW-1:0] elapsed;
  logic [SecW:0]   next_sum;
  logic [SecW:0]   next_wrap;

  assign tick_take_o = tick_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    force_on   = !cfg_i.mode_bits[rwct_pkg::ModeAuto] &&
                 cfg_i.mode_bits[rwct_pkg::ModeForceOn];
    force_off  = !force_on && cfg_i.mode_bits[rwct_pkg::ModeForceOff];
    has_window = cfg_i.mode_bits[rwct_pkg::ModeWindow];
    has_repeat = cfg_i.mode_bits[rwct_pkg::ModeRepeat];

    outside = 1'b0;
    if (has_window) begin
      if (cfg_i.window_start_minute <= cfg_i.window_end_minute) begin
        outside = (tick_i.now_min < cfg_i.window_start_minute) ||
                  (tick_i.now_min >= cfg_i.window_end_minute);
      end else begin
        outside = (tick_i.now_min >= cfg_i.window_end_minute) &&
                  (tick_i.now_min < cfg_i.window_start_minute);
      end
    end

    elapsed   = tick_i.at_sec - tsec_q;
    due       = !pend_q || ((tick_i.at_sec >= tsec_q) && (elapsed < rwct_pkg::WrapGuardC));
    phase_eff = phase_q;
    // an edited clock restarts the cycle into its off phase
    if (tick_i.edited) begin
      due       = 1'b1;
      phase_eff = 1'b1;
    end

    if (phase_eff) begin
      next_sum = (SecW+1)'(tick_i.at_sec)
               + (SecW+1)'(cfg_i.off_minutes) * (SecW+1)'(rwct_pkg::SecPerMin);
    end else begin
      next_sum = (SecW+1)'(tick_i.at_sec) + (SecW+1)'(cfg_i.on_seconds);
    end
    next_wrap = (next_sum >= (SecW+1)'(rwct_pkg::DaySeconds)) ?
                next_sum - (SecW+1)'(rwct_pkg::DaySeconds) : next_sum;

    phase_d = phase_q;
    pend_d  = pend_q;
    tsec_d  = tsec_q;
    stat_d  = stat_q;
    out_d.relay_on = 1'b0;

    if (force_off) begin
      stat_d = 1'b0;
    end else if (force_on) begin
      stat_d         = 1'b1;
      out_d.relay_on = 1'b1;
    end else if (!has_window && !has_repeat) begin
      stat_d = 1'b0;
    end else if (outside) begin
      stat_d  = 1'b0;
      phase_d = 1'b0;
      pend_d  = 1'b0;
    end else if (has_repeat) begin
      if (!due) begin
        phase_d        = phase_eff;
        out_d.relay_on = phase_eff;
      end else begin
        // flip phase and schedule the next toggle
        phase_d        = !phase_eff;
        stat_d         = !phase_eff;
        out_d.relay_on = !phase_eff;
        tsec_d         = next_wrap[SecW-1:0];
        pend_d         = 1'b1;
      end
    end else begin
      stat_d         = 1'b1;
      out_d.relay_on = 1'b1;
    end
    out_d.shown_on = stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      pend_q      <= 1'b0;
      tsec_q      <= '0;
      stat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tick_take_o) begin
        phase_q     <= phase_d;
        pend_q      <= pend_d;
        tsec_q      <= tsec_d;
        stat_q      <= stat_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (tick_take_o) begin
      out_q <= out_d;
    end
  end

endmodule

>>> rtl/relay_window_cycle_timer.sv
// One relay channel timer. Each input beat is a tick carrying hour, minute,
// second and a time-edited flag; each tick yields exactly one result beat
// with the relay drive and the displayed status. A tick is accepted every
// clock cycle when the result side keeps up; a result passes through the input
// register, then the result register that the channel state updates with in
// the same cycle, and is held there until taken. Configuration is written
// through a separate port, index 0 mode bits, 1 window start, 2 window end,
// 3 off minutes, 4 on seconds, and must only be written while no tick is in
// flight.
// ----------------------------------------------------------------------------
// relay_window_cycle_timer
// Top level: configuration registers, tick input stage and relay decision.
// ----------------------------------------------------------------------------
module relay_window_cycle_timer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rwct_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rwct_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [10:0]    cfg_data_i
);

  rwct_pkg::cfg_t  cfg;
  rwct_pkg::tick_t tick;
  logic            tick_valid;
  logic            tick_take;

  rwct_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rwct_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .tick_valid_o (tick_valid),
    .tick_take_i  (tick_take),
    .tick_o       (tick)
  );

  rwct_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .tick_valid_i (tick_valid),
    .tick_take_o  (tick_take),
    .tick_i       (tick),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for one relay channel timer: ticks go in over a
// valid/ready channel, every result beat is compared against an in-bench
// prediction of the relay drive and the displayed status.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned TickW       = $bits(rwct_pkg::in_t);

  localparam int unsigned SecW         = rwct_pkg::SecW;
  localparam int unsigned SecPerMin    = rwct_pkg::SecPerMin;
  localparam int unsigned SecPerHour   = rwct_pkg::SecPerHour;
  localparam int unsigned DaySeconds   = rwct_pkg::DaySeconds;
  localparam int unsigned WrapGuard    = rwct_pkg::WrapGuard;
  localparam int unsigned ModeAuto     = rwct_pkg::ModeAuto;
  localparam int unsigned ModeForceOn  = rwct_pkg::ModeForceOn;
  localparam int unsigned ModeForceOff = rwct_pkg::ModeForceOff;
  localparam int unsigned ModeWindow   = rwct_pkg::ModeWindow;
  localparam int unsigned ModeRepeat   = rwct_pkg::ModeRepeat;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  rwct_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  rwct_pkg::out_t out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [2:0]     cfg_index_i = '0;
  logic [10:0]    cfg_data_i  = '0;

  // channel configuration and state as predicted
  logic [4:0]      mode_q;
  logic [10:0]     win_start_q;
  logic [10:0]     win_end_q;
  logic [9:0]      off_min_q;
  logic [9:0]      on_sec_q;
  logic            phase_on_q;
  logic            toggle_set_q;
  logic [SecW-1:0] toggle_at_q;
  logic            status_q;

  rwct_pkg::out_t relay_expect_q[$];
  rwct_pkg::out_t oldest_relay;
  int unsigned ticks_sent     = 0;
  int unsigned beats_checked  = 0;
  int unsigned mismatches     = 0;
  int unsigned repeat_toggles = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_idle_pct    = 0;
  logic        rx_hold        = 1'b0;

  relay_window_cycle_timer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               relay_expect_q.size());
      $display("** relay_window_cycle_timer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (relay_expect_q.size() == 0) begin
        $error("result beat with no tick pending: relay_on=%0b shown_on=%0b",
               out_data_o.relay_on, out_data_o.shown_on);
        mismatches++;
      end else begin
        oldest_relay = relay_expect_q.pop_front();
        beats_checked++;
        if (out_data_o.relay_on !== oldest_relay.relay_on) begin
          $error("relay_on: expected %0b, got %0b", oldest_relay.relay_on,
                 out_data_o.relay_on);
          mismatches++;
        end
        if (out_data_o.shown_on !== oldest_relay.shown_on) begin
          $error("shown_on: expected %0b, got %0b", oldest_relay.shown_on,
                 out_data_o.shown_on);
          mismatches++;
        end
      end
    end
  end

  function automatic void reset_channel_model();
    mode_q       = 5'd4;
    win_start_q  = 11'd0;
    win_end_q    = 11'd1439;
    off_min_q    = 10'd1;
    on_sec_q     = 10'd10;
    phase_on_q   = 1'b0;
    toggle_set_q = 1'b0;
    toggle_at_q  = '0;
    status_q     = 1'b0;
  endfunction

  // Advance the channel by one tick and return the relay and status after it.
  function automatic rwct_pkg::out_t next_relay_state(rwct_pkg::in_t t);
    logic           force_on;
    logic           force_off;
    logic           outside;
    logic           due;
    int unsigned    now_min;
    int unsigned    day_sec;
    rwct_pkg::out_t r;
    force_on  = !mode_q[ModeAuto] && mode_q[ModeForceOn];
    force_off = !force_on && mode_q[ModeForceOff];
    now_min   = t.hour * SecPerMin + t.minute;
    day_sec   = (t.hour * SecPerHour + t.minute * SecPerMin + t.second) % DaySeconds;
    r.relay_on = 1'b0;
    if (force_off) begin
      status_q = 1'b0;
    end else if (force_on) begin
      status_q   = 1'b1;
      r.relay_on = 1'b1;
    end else if (!mode_q[ModeWindow] && !mode_q[ModeRepeat]) begin
      status_q = 1'b0;
    end else begin
      outside = 1'b0;
      if (mode_q[ModeWindow]) begin
        // a start past the end means the window wraps over midnight
        if (win_start_q <= win_end_q)
          outside = (now_min < win_start_q) || (now_min >= win_end_q);
        else
          outside = (now_min >= win_end_q) && (now_min < win_start_q);
      end
      if (outside) begin
        status_q     = 1'b0;
        phase_on_q   = 1'b0;
        toggle_set_q = 1'b0;
      end else if (mode_q[ModeRepeat]) begin
        due = !toggle_set_q ||
              (day_sec >= toggle_at_q && day_sec - toggle_at_q < WrapGuard);
        // an edited clock restarts the cycle in its off phase
        if (t.time_edited) begin
          due        = 1'b1;
          phase_on_q = 1'b1;
        end
        if (!due) begin
          r.relay_on = phase_on_q;
        end else begin
          repeat_toggles++;
          toggle_set_q = 1'b1;
          if (phase_on_q) begin
            status_q    = 1'b0;
            phase_on_q  = 1'b0;
            toggle_at_q = SecW'((day_sec + off_min_q * SecPerMin) % DaySeconds);
          end else begin
            status_q    = 1'b1;
            phase_on_q  = 1'b1;
            r.relay_on  = 1'b1;
            toggle_at_q = SecW'((day_sec + on_sec_q) % DaySeconds);
          end
        end
      end else begin
        status_q   = 1'b1;
        r.relay_on = 1'b1;
      end
    end
    r.shown_on = status_q;
    return r;
  endfunction

  function automatic rwct_pkg::in_t tick_at(int unsigned day_sec, logic edited);
    rwct_pkg::in_t t;
    t.hour        = 5'(day_sec / SecPerHour);
    t.minute      = 6'((day_sec / SecPerMin) % SecPerMin);
    t.second      = 6'(day_sec % SecPerMin);
    t.time_edited = edited;
    return t;
  endfunction

  task automatic send_tick(input rwct_pkg::in_t tick);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= rwct_pkg::in_t'(TickW'($urandom));
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    relay_expect_q.push_back(next_relay_state(tick));
    ticks_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (relay_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller drops it once its writes are done.
  task automatic cfg_write(input rwct_pkg::cfg_idx_e idx, input int unsigned value);
    logic [10:0] data_v;
    data_v = 11'(value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data_v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rwct_pkg::CfgMode:        mode_q      = data_v[4:0];
      rwct_pkg::CfgWindowStart: win_start_q = data_v;
      rwct_pkg::CfgWindowEnd:   win_end_q   = data_v;
      rwct_pkg::CfgOffMinutes:  off_min_q   = data_v[9:0];
      rwct_pkg::CfgOnSeconds:   on_sec_q    = data_v[9:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input int unsigned mode_v);
    wait_for_results();
    cfg_write(rwct_pkg::CfgMode, mode_v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_channel(input int unsigned mode_v, input int unsigned start_v,
                                   input int unsigned end_v, input int unsigned off_v,
                                   input int unsigned on_v);
    wait_for_results();
    cfg_write(rwct_pkg::CfgMode, mode_v);
    cfg_write(rwct_pkg::CfgWindowStart, start_v);
    cfg_write(rwct_pkg::CfgWindowEnd, end_v);
    cfg_write(rwct_pkg::CfgOffMinutes, off_v);
    cfg_write(rwct_pkg::CfgOnSeconds, on_v);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset mode is force off; the other registers keep their reset values.
  task automatic test_reset_state();
    send_tick(tick_at(12 * 3600, 1'b0));
    set_mode((1 << ModeAuto) | (1 << ModeWindow) | (1 << ModeRepeat));
    send_tick(tick_at(23 * 3600 + 58 * 60, 1'b0));
    send_tick(tick_at(23 * 3600 + 58 * 60 + 10, 1'b0));
    send_tick(tick_at(23 * 3600 + 59 * 60, 1'b0));
  endtask

  task automatic test_mode_decode();
    int unsigned modes[6];
    modes = '{(1 << ModeForceOn),
              (1 << ModeForceOn) | (1 << ModeForceOff),
              (1 << ModeAuto) | (1 << ModeForceOn),
              (1 << ModeAuto) | (1 << ModeForceOn) | (1 << ModeForceOff) |
              (1 << ModeWindow) | (1 << ModeRepeat),
              (1 << ModeAuto) | (1 << ModeWindow),
              0};
    foreach (modes[m]) begin
      set_mode(modes[m]);
      send_tick(tick_at(12 * 3600, 1'b0));
    end
  endtask

  task automatic test_window_edges();
    configure_channel((1 << ModeAuto) | (1 << ModeWindow), 600, 720, 1, 10);
    send_tick(tick_at(9 * 3600 + 59 * 60 + 59, 1'b0));
    send_tick(tick_at(10 * 3600, 1'b0));
    send_tick(tick_at(11 * 3600 + 59 * 60 + 59, 1'b0));
    send_tick(tick_at(12 * 3600, 1'b0));
    configure_channel((1 << ModeAuto) | (1 << ModeWindow), 1380, 60, 1, 10);
    send_tick(tick_at(23 * 3600, 1'b0));
    send_tick(tick_at(3600, 1'b0));
    configure_channel((1 << ModeAuto) | (1 << ModeWindow), 500, 500, 1, 10);
    send_tick(tick_at(8 * 3600 + 20 * 60, 1'b0));
    // all-ones tick lands inside a window that ends past the last legal minute
    configure_channel(1 << ModeWindow, 0, 2047, 1023, 1023);
    send_tick('1);
  endtask

  task automatic test_repeat_cycle();
    configure_channel((1 << ModeAuto) | (1 << ModeRepeat), 0, 1439, 1, 10);
    send_tick(tick_at(0, 1'b0));
    send_tick(tick_at(9, 1'b0));
    send_tick(tick_at(10, 1'b0));
    send_tick(tick_at(30, 1'b1));
    send_tick(tick_at(90, 1'b0));
    // far past the toggle time: the guard treats it as not yet due
    send_tick(tick_at(86395, 1'b0));
    send_tick(tick_at(86395, 1'b1));
    send_tick(tick_at(55, 1'b0));
    configure_channel(1 << ModeRepeat, 0, 1439, 0, 0);
    send_tick(tick_at(12 * 3600, 1'b0));
    send_tick(tick_at(12 * 3600, 1'b0));
  endtask

  task automatic test_random_ticks();
    int unsigned   day_clock;
    int unsigned   mode_v;
    int unsigned   low_v;
    int unsigned   start_v;
    int unsigned   end_v;
    int unsigned   off_v;
    int unsigned   on_v;
    int unsigned   step_v;
    int unsigned   roll;
    rwct_pkg::in_t tick;
    for (int pass_idx = 0; pass_idx < 3; pass_idx++) begin
      case (pass_idx)
        0: begin tx_idle_pct = 25; rx_idle_pct = 69; end
        1: begin tx_idle_pct = 69; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (int batch = 0; batch < 11; batch++) begin
        if ($urandom_range(9) == 0) begin
          mode_v = $urandom_range(31);
        end else begin
          // keep the channel out of the forced modes with repeat on
          low_v = $urandom_range(2);
          if (low_v == 2) low_v = 3;
          mode_v = (1 << ModeRepeat) | ($urandom_range(1) << ModeWindow) | low_v;
        end
        if ($urandom_range(7) == 0) begin
          start_v = $urandom_range(2047);
          end_v   = $urandom_range(2047);
        end else begin
          start_v = $urandom_range(1439);
          end_v   = $urandom_range(1439);
        end
        case ($urandom_range(9))
          0: off_v = $urandom_range(1023);
          1: off_v = 0;
          default: off_v = $urandom_range(1, 3);
        endcase
        case ($urandom_range(9))
          0: on_v = $urandom_range(1023);
          1: on_v = 0;
          default: on_v = $urandom_range(1, 60);
        endcase
        configure_channel(mode_v, start_v, end_v, off_v, on_v);
        if ((mode_v & (1 << ModeWindow)) != 0)
          day_clock = (start_v * SecPerMin + DaySeconds - 120 + $urandom_range(600))
                      % DaySeconds;
        else
          day_clock = $urandom_range(DaySeconds - 1);
        for (int n = 0; n < 60; n++) begin
          roll = $urandom_range(99);
          if (roll < 8) begin
            tick = rwct_pkg::in_t'(TickW'($urandom));
          end else begin
            roll = $urandom_range(99);
            if (roll < 80)      step_v = $urandom_range(1, 6);
            else if (roll < 95) step_v = $urandom_range(7, 200);
            else                step_v = $urandom_range(DaySeconds - 1);
            day_clock = (day_clock + step_v) % DaySeconds;
            tick = tick_at(day_clock, $urandom_range(99) < 3);
          end
          send_tick(tick);
        end
      end
    end
  endtask

  // Stall the result side long enough to back the block up into its input.
  task automatic test_output_hold();
    int unsigned day_clock;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure_channel((1 << ModeAuto) | (1 << ModeRepeat), 0, 1439, 0, 3);
    day_clock = $urandom_range(DaySeconds - 1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        for (int n = 0; n < 40; n++) begin
          day_clock = (day_clock + 1) % DaySeconds;
          send_tick(tick_at(day_clock, 1'b0));
        end
      end
    join
  endtask

  initial begin
    reset_channel_model();
    tx_idle_pct = 25;
    rx_idle_pct = 69;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_mode_decode();
    test_window_edges();
    test_repeat_cycle();
    test_random_ticks();
    test_output_hold();
    wait_for_results();
    $display("Sent %0d ticks and checked %0d result beats, %0d repeat toggles predicted,",
             ticks_sent, beats_checked, repeat_toggles);
    $display("under three idle profiles and one long output stall (%0d mismatches).",
             mismatches);
    if (mismatches == 0)
      $display("** relay_window_cycle_timer: PASSED **");
    else
      $display("** relay_window_cycle_timer: FAILED **");
    $finish;
  end

endmodule

>>> files.f
rtl/rwct_pkg.sv
rtl/rwct_cfg.sv
rtl/rwct_in_stage.sv
rtl/rwct_core.sv
rtl/relay_window_cycle_timer.sv
verif/tb.sv
